@@ rtl/bpc_pkg.sv @@
`default_nettype none

package bpc_pkg;

   // Field widths
   localparam int MD_W     = 14;
   localparam int WIDE_W   = 20;
   localparam int NARROW_W = 11;

   localparam logic [MD_W-1:0] MODULUS_RESET = MD_W'(10007);

   // Pascal row store
   localparam int MAX_K     = 1024;
   localparam int ROW_DEPTH = MAX_K + 1;
   localparam int ROW_AW    = $clog2(ROW_DEPTH);

   // Serial modular multiplier: one multiplier bit per cycle
   localparam int MM_STEPS = WIDE_W;
   localparam int MM_CW    = $clog2(MM_STEPS);

   typedef struct packed {
      logic              start;
      logic [WIDE_W-1:0] op_a;
      logic [MD_W-1:0]   op_x;
   } mm_req_type;

   typedef struct packed {
      logic            done;
      logic [MD_W-1:0] result;
   } mm_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RED,
      S_PW_CHK,
      S_PW_MUL,
      S_PW_SQR,
      S_CLEAR,
      S_ROW_START,
      S_ROW,
      S_FETCH,
      S_FETCH_WAIT,
      S_MUL_AB,
      S_MUL_C,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

@@ rtl/bpc_mulmod.sv @@
`default_nettype none

// Shift-and-add modular multiplier: result = op_a * op_x mod md.
// op_a is scanned MSB first, one bit per cycle; op_x must be below md.
module bpc_mulmod (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [bpc_pkg::MD_W-1:0]  md,
   input  wire bpc_pkg::mm_req_type       mm_req,
   output bpc_pkg::mm_rsp_type            mm_rsp
);
   import bpc_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [MM_CW-1:0]    cnt_ff, cnt_in;
   logic [WIDE_W-1:0]   a_ff, a_in;
   logic [MD_W-1:0]     x_ff, x_in;
   logic [MD_W-1:0]     acc_ff, acc_in;

   logic [MD_W+1:0]     dbl_sum;
   logic [MD_W+1:0]     md_x1;
   logic [MD_W+1:0]     md_x2;
   logic [MD_W+1:0]     step_val;

   // One step: acc = (2*acc + bit*x) mod md, sum stays below 3*md
   always_comb begin
      md_x1   = (MD_W+2)'(md);
      md_x2   = (MD_W+2)'({md, 1'b0});
      dbl_sum = (MD_W+2)'({acc_ff, 1'b0}) + (a_ff[WIDE_W-1] ? (MD_W+2)'(x_ff) : '0);
      if (dbl_sum >= md_x2) begin
         step_val = dbl_sum - md_x2;
      end else if (dbl_sum >= md_x1) begin
         step_val = dbl_sum - md_x1;
      end else begin
         step_val = dbl_sum;
      end
   end

   // Sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      x_in    = x_ff;
      acc_in  = acc_ff;
      if (busy_ff) begin
         acc_in = MD_W'(step_val);
         a_in   = {a_ff[WIDE_W-2:0], 1'b0};
         cnt_in = cnt_ff - MM_CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (mm_req.start) begin
         busy_in = 1'b1;
         cnt_in  = MM_CW'(MM_STEPS - 1);
         a_in    = mm_req.op_a;
         x_in    = mm_req.op_x;
         acc_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      x_ff   <= x_in;
      acc_ff <= acc_in;
   end

   assign mm_rsp.done   = done_ff;
   assign mm_rsp.result = acc_ff;

endmodule

`default_nettype wire

@@ rtl/binomial_power_coefficient_unit.sv @@
`default_nettype none

// Computes a^n * b^m * C(k, min(n,m)) mod modulus, the coefficient of x^n y^m in
// (ax+by)^k, one word at a time. k is clamped to 1024. Both powers run
// square-and-multiply on one bit-serial modular multiplier (up to two
// multiplies per exponent bit), and C comes from Pascal rows rebuilt
// in a 1025 x 14 single-port-read row RAM. With r = min(n,m), clearing writes
// entries r..0, then rows i = 1..k are rebuilt in turn. Both are skipped
// when r is 0 or above k. For large k and r the row sweep dominates the
// time a word takes. A result waits in an output register, so the next word
// is taken while the last one is still unread.
// A modulus of 0 or 1 gives 0.
module binomial_power_coefficient_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // configuration: modulus
   input  wire logic                         csr_wr_en,
   input  wire logic [bpc_pkg::MD_W-1:0]     csr_wr_data,
   // request: base_a[19:0], base_b[39:20], total_power[50:40],
   //          exp_n[61:51], exp_m[72:62], zero fill [79:73]
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [79:0]                  req_tdata,
   // response: coefficient[13:0], zero fill [15:14]
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [15:0]                       rsp_tdata
);
   import bpc_pkg::*;

   state_type            state_ff, state_in;

   logic [MD_W-1:0]      md_ff;
   logic [WIDE_W-1:0]    a_ff, a_in;
   logic [WIDE_W-1:0]    b_ff, b_in;
   logic [NARROW_W-1:0]  k_ff, k_in;
   logic [NARROW_W-1:0]  n_ff, n_in;
   logic [NARROW_W-1:0]  m_ff, m_in;
   logic [NARROW_W-1:0]  r_ff, r_in;
   logic [NARROW_W-1:0]  e_ff, e_in;
   logic [NARROW_W-1:0]  i_ff, i_in;
   logic                 sel_ff, sel_in;
   logic [MD_W-1:0]      acc_ff, acc_in;
   logic [MD_W-1:0]      sq_ff, sq_in;
   logic [MD_W-1:0]      pa_ff, pa_in;
   logic [MD_W-1:0]      pb_ff, pb_in;
   logic [MD_W-1:0]      c_ff, c_in;
   logic [MD_W-1:0]      t_ff, t_in;
   logic [MD_W-1:0]      res_ff, res_in;
   logic [ROW_AW-1:0]    cnt_ff, cnt_in;
   logic [ROW_AW-1:0]    rd_addr_ff, rd_addr_in;
   logic                 rd_go_ff, rd_go_in;
   logic                 rv_ff, rv_in;
   logic [ROW_AW-1:0]    rv_addr_ff, rv_addr_in;
   logic [MD_W-1:0]      hold_ff, hold_in;
   logic                 hold_v_ff, hold_v_in;
   logic                 issued_ff, issued_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MD_W-1:0]      rsp_data_ff, rsp_data_in;

   // Row RAM
   logic [MD_W-1:0]      row_mem [ROW_DEPTH];
   logic [MD_W-1:0]      mem_rdata_ff;
   logic                 mem_we;
   logic [ROW_AW-1:0]    mem_waddr;
   logic [MD_W-1:0]      mem_wdata;
   logic                 mem_re;
   logic [ROW_AW-1:0]    mem_raddr;

   mm_req_type           mm_req;
   mm_rsp_type           mm_rsp;
   logic                 mul_state;

   logic                 req_acc;
   logic [WIDE_W-1:0]    f_base_a;
   logic [WIDE_W-1:0]    f_base_b;
   logic [NARROW_W-1:0]  f_total;
   logic [NARROW_W-1:0]  f_exp_n;
   logic [NARROW_W-1:0]  f_exp_m;
   logic                 row_end;
   logic                 r_over_k;
   logic [NARROW_W-1:0]  row_top;
   logic [MD_W:0]        pas_sum;
   logic [MD_W-1:0]      pas_mod;

   assign f_base_a = req_tdata[19:0];
   assign f_base_b = req_tdata[39:20];
   assign f_total  = req_tdata[50:40];
   assign f_exp_n  = req_tdata[61:51];
   assign f_exp_m  = req_tdata[72:62];

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 16'(rsp_data_ff);

   assign row_end  = rv_ff && (rv_addr_ff == '0);
   assign r_over_k = (r_ff > k_ff);
   assign row_top  = (i_ff < r_ff) ? i_ff : r_ff;

   // Pascal add: both terms below md
   always_comb begin
      pas_sum = (MD_W+1)'(hold_ff) + (MD_W+1)'(mem_rdata_ff);
      if (pas_sum >= (MD_W+1)'(md_ff)) begin
         pas_mod = MD_W'(pas_sum - (MD_W+1)'(md_ff));
      end else begin
         pas_mod = MD_W'(pas_sum);
      end
   end

   bpc_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .md     (md_ff),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               state_in = (md_ff < MD_W'(2)) ? S_DONE : S_RED;
            end
         end
         S_RED: begin
            if (mm_rsp.done) state_in = S_PW_CHK;
         end
         S_PW_CHK: begin
            if (e_ff == '0) begin
               if (!sel_ff) begin
                  state_in = S_RED;
               end else if (r_over_k || (r_ff == '0)) begin
                  state_in = S_MUL_AB;
               end else begin
                  state_in = S_CLEAR;
               end
            end else if (e_ff[0]) begin
               state_in = S_PW_MUL;
            end else begin
               state_in = S_PW_SQR;
            end
         end
         S_PW_MUL: begin
            if (mm_rsp.done) state_in = S_PW_SQR;
         end
         S_PW_SQR: begin
            if (mm_rsp.done) state_in = S_PW_CHK;
         end
         S_CLEAR: begin
            if (cnt_ff == '0) state_in = S_ROW_START;
         end
         S_ROW_START: begin
            state_in = S_ROW;
         end
         S_ROW: begin
            if (row_end) state_in = (i_ff == k_ff) ? S_FETCH : S_ROW_START;
         end
         S_FETCH: begin
            state_in = S_FETCH_WAIT;
         end
         S_FETCH_WAIT: begin
            state_in = S_MUL_AB;
         end
         S_MUL_AB: begin
            if (mm_rsp.done) state_in = S_MUL_C;
         end
         S_MUL_C: begin
            if (mm_rsp.done) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath, memory and multiplier controls
   always_comb begin
      a_in        = a_ff;
      b_in        = b_ff;
      k_in        = k_ff;
      n_in        = n_ff;
      m_in        = m_ff;
      r_in        = r_ff;
      e_in        = e_ff;
      i_in        = i_ff;
      sel_in      = sel_ff;
      acc_in      = acc_ff;
      sq_in       = sq_ff;
      pa_in       = pa_ff;
      pb_in       = pb_ff;
      c_in        = c_ff;
      t_in        = t_ff;
      res_in      = res_ff;
      cnt_in      = cnt_ff;
      rd_addr_in  = rd_addr_ff;
      rd_go_in    = rd_go_ff;
      rv_in       = 1'b0;
      rv_addr_in  = rv_addr_ff;
      hold_in     = hold_ff;
      hold_v_in   = hold_v_ff;
      mem_we      = 1'b0;
      mem_waddr   = cnt_ff;
      mem_wdata   = '0;
      mem_re      = 1'b0;
      mem_raddr   = rd_addr_ff;
      mul_state   = 1'b0;
      mm_req.op_a = '0;
      mm_req.op_x = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               a_in   = f_base_a;
               b_in   = f_base_b;
               k_in   = (f_total > NARROW_W'(MAX_K)) ? NARROW_W'(MAX_K) : f_total;
               n_in   = f_exp_n;
               m_in   = f_exp_m;
               r_in   = (f_exp_n < f_exp_m) ? f_exp_n : f_exp_m;
               sel_in = 1'b0;
               res_in = '0;
            end
         end
         S_RED: begin
            // base mod md
            mul_state   = 1'b1;
            mm_req.op_a = sel_ff ? b_ff : a_ff;
            mm_req.op_x = MD_W'(1);
            if (mm_rsp.done) begin
               sq_in  = mm_rsp.result;
               acc_in = MD_W'(1);
               e_in   = sel_ff ? m_ff : n_ff;
            end
         end
         S_PW_CHK: begin
            if (e_ff == '0) begin
               if (!sel_ff) begin
                  pa_in  = acc_ff;
                  sel_in = 1'b1;
               end else begin
                  pb_in  = acc_ff;
                  c_in   = r_over_k ? '0 : MD_W'(1);
                  cnt_in = ROW_AW'(r_ff);
                  i_in   = NARROW_W'(1);
               end
            end
         end
         S_PW_MUL: begin
            mul_state   = 1'b1;
            mm_req.op_a = WIDE_W'(acc_ff);
            mm_req.op_x = sq_ff;
            if (mm_rsp.done) acc_in = mm_rsp.result;
         end
         S_PW_SQR: begin
            mul_state   = 1'b1;
            mm_req.op_a = WIDE_W'(sq_ff);
            mm_req.op_x = sq_ff;
            if (mm_rsp.done) begin
               sq_in = mm_rsp.result;
               e_in  = e_ff >> 1;
            end
         end
         S_CLEAR: begin
            // entries r..1 to zero, entry 0 to one
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = (cnt_ff == '0) ? MD_W'(1) : '0;
            if (cnt_ff != '0) cnt_in = cnt_ff - ROW_AW'(1);
         end
         S_ROW_START: begin
            rd_addr_in = ROW_AW'(row_top);
            rd_go_in   = 1'b1;
            hold_v_in  = 1'b0;
         end
         S_ROW: begin
            // read descending; write j once old row[j-1] arrives
            if (rd_go_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = rd_addr_ff;
               rv_in      = 1'b1;
               rv_addr_in = rd_addr_ff;
               if (rd_addr_ff == '0) begin
                  rd_go_in = 1'b0;
               end else begin
                  rd_addr_in = rd_addr_ff - ROW_AW'(1);
               end
            end
            if (rv_ff) begin
               if (hold_v_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = rv_addr_ff + ROW_AW'(1);
                  mem_wdata = pas_mod;
               end
               hold_in   = mem_rdata_ff;
               hold_v_in = 1'b1;
               if (row_end) begin
                  hold_v_in = 1'b0;
                  i_in      = i_ff + NARROW_W'(1);
               end
            end
         end
         S_FETCH: begin
            mem_re    = 1'b1;
            mem_raddr = ROW_AW'(r_ff);
         end
         S_FETCH_WAIT: begin
            c_in = mem_rdata_ff;
         end
         S_MUL_AB: begin
            mul_state   = 1'b1;
            mm_req.op_a = WIDE_W'(pa_ff);
            mm_req.op_x = pb_ff;
            if (mm_rsp.done) t_in = mm_rsp.result;
         end
         S_MUL_C: begin
            mul_state   = 1'b1;
            mm_req.op_a = WIDE_W'(t_ff);
            mm_req.op_x = c_ff;
            if (mm_rsp.done) res_in = mm_rsp.result;
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase

      // one multiply per visit to a multiply state
      mm_req.start = mul_state && !issued_ff;
      if (mm_req.start) begin
         issued_in = 1'b1;
      end else if (mm_rsp.done) begin
         issued_in = 1'b0;
      end else begin
         issued_in = issued_ff;
      end

      // output register
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         md_ff        <= MODULUS_RESET;
         rd_go_ff     <= 1'b0;
         rv_ff        <= 1'b0;
         hold_v_ff    <= 1'b0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_go_ff     <= rd_go_in;
         rv_ff        <= rv_in;
         hold_v_ff    <= hold_v_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) md_ff <= csr_wr_data;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      k_ff        <= k_in;
      n_ff        <= n_in;
      m_ff        <= m_in;
      r_ff        <= r_in;
      e_ff        <= e_in;
      i_ff        <= i_in;
      sel_ff      <= sel_in;
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      c_ff        <= c_in;
      t_ff        <= t_in;
      res_ff      <= res_in;
      cnt_ff      <= cnt_in;
      rd_addr_ff  <= rd_addr_in;
      rv_addr_ff  <= rv_addr_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Row RAM, registered read
   always_ff @(posedge clock) begin
      if (mem_we) row_mem[mem_waddr] <= mem_wdata;
      if (mem_re) mem_rdata_ff <= row_mem[mem_raddr];
   end

endmodule

`default_nettype wire

@@ rtl/bpc_checker.sv @@
`default_nettype none

module bpc_checker (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [bpc_pkg::MD_W-1:0]  csr_wr_data,
   input  wire logic                      req_tvalid,
   input  wire logic                      req_tready,
   input  wire logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic [15:0]               rsp_tdata
);
   import bpc_pkg::*;

   logic [MD_W-1:0] md_ff;
   logic [1:0]      out_cnt_ff, out_cnt_in;
   logic            req_acc;
   logic            rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Shadow modulus and words in flight
   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (req_acc && !rsp_acc) begin
         out_cnt_in = out_cnt_ff + 2'd1;
      end else if (!req_acc && rsp_acc) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         md_ff      <= MODULUS_RESET;
         out_cnt_ff <= '0;
      end else begin
         out_cnt_ff <= out_cnt_in;
         if (csr_wr_en) md_ff <= csr_wr_data;
      end
   end

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // coefficient is reduced
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (md_ff >= MD_W'(2)) |-> (rsp_tdata[MD_W-1:0] < md_ff)
         && (rsp_tdata[15:MD_W] == '0))
      else $error("coefficient not below modulus");

   a_rsp_small_md: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (md_ff < MD_W'(2)) |-> (rsp_tdata == '0))
      else $error("nonzero coefficient for modulus below two");

   // no result without a request, at most one waiting and one in work
   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || (out_cnt_ff != 2'd0)) && (out_cnt_ff != 2'd3))
      else $error("request and response counts out of step");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind binomial_power_coefficient_unit bpc_checker u_bpc_checker (
   .clock       (clock),
   .reset       (reset),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata)
);

`default_nettype wire
